// ===== hdl/dssd_pkg.sv =====
// Shared types, constants and digit helpers for the seven-segment frame generator.
package dssd_pkg;

  localparam int ValueW    = 16;
  localparam int DigitW    = 4;
  localparam int NumDigits = 5;
  localparam int NumStages = NumDigits - 1;
  localparam int IdxW      = 3;
  localparam int SegW      = 8;
  localparam int ProdW     = ValueW + DigitW;

  localparam logic [ValueW-1:0] PLACE [NumStages] = '{
    16'd10000, 16'd1000, 16'd100, 16'd10
  };

  // Select byte of the ten-thousands position; lower digits shift the low bit up.
  localparam logic [SegW-1:0] FIRST_SELECT_BIT = 8'h08;
  localparam logic [IdxW-1:0] UNITS_IDX        = 3'd4;

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [NumStages-1:0][DigitW-1:0] upper_digits_t;

  typedef struct packed {
    logic [NumDigits-1:0][DigitW-1:0] digits;  // index 0 is the ten-thousands digit
    logic [IdxW-1:0]                  first;   // index of the first digit shown
  } dssd_entry_t;

  typedef struct packed {
    digit_t            digit;
    logic [ValueW-1:0] rest;
  } dssd_div_t;

  // One decimal digit by parallel compares against the multiples of the place value.
  function automatic dssd_div_t extract_digit(logic [ValueW-1:0] rest,
                                              logic [ValueW-1:0] place);
    dssd_div_t        res;
    logic [ProdW-1:0] prod;
    res.digit = '0;
    res.rest  = rest;
    for (int k = 1; k <= 9; k++) begin
      prod = ProdW'(k) * ProdW'(place);
      if ({{DigitW{1'b0}}, rest} >= prod) begin
        res.digit = DigitW'(k);
        res.rest  = rest - prod[ValueW-1:0];
      end
    end
    return res;
  endfunction

  // Common-cathode pattern, bit0 = a up to bit6 = g, dp always off.
  function automatic logic [SegW-1:0] seg_pattern(digit_t d);
    logic [SegW-1:0] seg;
    unique case (d)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      default: seg = 8'h6f;
    endcase
    return seg;
  endfunction

  function automatic logic [SegW-1:0] select_byte(logic [IdxW-1:0] idx);
    return ~(FIRST_SELECT_BIT << idx);
  endfunction

endpackage

// ===== hdl/dssd_front.sv =====
// Front end: accepts values and splits them into decimal digits in a four-stage pipeline.
module dssd_front import dssd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] in_value_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output dssd_entry_t       q_entry_o
);

  logic          [NumStages-1:0] valid_q, valid_d;
  logic          [ValueW-1:0]    rest_q   [NumStages];
  upper_digits_t                 digits_q [NumStages];

  dssd_div_t     res    [NumStages];
  upper_digits_t nxt    [NumStages];
  logic          [NumStages-1:0] move, free;

  // Stage s extracts the digit of PLACE[s]; the last stage hands off to the queue.
  always_comb begin
    for (int s = 0; s < NumStages; s++) begin
      res[s]    = extract_digit(rest_q[s], PLACE[s]);
      nxt[s]    = digits_q[s];
      nxt[s][s] = res[s].digit;
    end
    move[NumStages-1] = valid_q[NumStages-1] && q_ready_i;
    free[NumStages-1] = !valid_q[NumStages-1] || move[NumStages-1];
    for (int s = NumStages - 2; s >= 0; s--) begin
      move[s] = valid_q[s] && free[s+1];
      free[s] = !valid_q[s] || move[s];
    end
    valid_d[0] = (in_valid_i && free[0]) || (valid_q[0] && !move[0]);
    for (int s = 1; s < NumStages; s++) begin
      valid_d[s] = move[s-1] || (valid_q[s] && !move[s]);
    end
  end

  assign in_ready_o = free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && free[0]) begin
      rest_q[0]   <= in_value_i;
      digits_q[0] <= '0;
    end
    for (int s = 1; s < NumStages; s++) begin
      if (move[s-1]) begin
        rest_q[s]   <= res[s-1].rest;
        digits_q[s] <= nxt[s-1];
      end
    end
  end

  // Classify the run: the first nonzero digit, the units digit at the latest.
  always_comb begin
    q_entry_o.digits = {res[NumStages-1].rest[DigitW-1:0], nxt[NumStages-1]};
    priority if (q_entry_o.digits[0] != '0) begin
      q_entry_o.first = 3'd0;
    end else if (q_entry_o.digits[1] != '0) begin
      q_entry_o.first = 3'd1;
    end else if (q_entry_o.digits[2] != '0) begin
      q_entry_o.first = 3'd2;
    end else if (q_entry_o.digits[3] != '0) begin
      q_entry_o.first = 3'd3;
    end else begin
      q_entry_o.first = UNITS_IDX;
    end
  end

  assign q_valid_o = valid_q[NumStages-1];

endmodule

// ===== hdl/dssd_queue.sv =====
// Short register queue that decouples digit extraction from frame output.
module dssd_queue import dssd_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  output logic        wr_ready_o,
  input  dssd_entry_t wr_entry_i,
  output logic        rd_valid_o,
  input  logic        rd_pop_i,
  output dssd_entry_t rd_entry_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  dssd_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// ===== hdl/dssd_back.sv =====
// Back end: walks the shown digits of each queued value and registers one frame per cycle unless m_axis stalls.
module dssd_back import dssd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  dssd_entry_t     q_entry_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SegW-1:0] out_segments_o,
  output logic [SegW-1:0] out_select_o,
  output logic            out_last_o
);

  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d, idx;
  logic            valid_q, valid_d;
  logic [SegW-1:0] seg_q, sel_q;
  logic            last_q;
  logic            load;

  assign idx  = busy_q ? idx_q : q_entry_i.first;
  assign load = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    valid_d = valid_q && !out_ready_i;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (idx == UNITS_IDX) begin
        q_pop_o = 1'b1;
        busy_d  = 1'b0;
      end else begin
        busy_d  = 1'b1;
        idx_d   = idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seg_q  <= seg_pattern(q_entry_i.digits[idx]);
      sel_q  <= select_byte(idx);
      last_q <= (idx == UNITS_IDX);
    end
  end

  assign out_valid_o    = valid_q;
  assign out_segments_o = seg_q;
  assign out_select_o   = sel_q;
  assign out_last_o     = last_q;

endmodule

// ===== hdl/decimal_seven_segment_display_frames_core.sv =====
// Top level of the decimal seven-segment frame generator.
//
//   Channel   Dir  Signals                              Content
//   s_axis    in   s_axis_tvalid/tready/tdata[15:0]     value to show, one request each
//   m_axis    out  m_axis_tvalid/tready/tdata[15:0]     one frame per shown digit
//                  m_axis_tlast                         set on the units-digit frame
//
// The back end issues one frame per cycle while m_axis is not stalled, so a value with n
// shown digits (1 to 5) occupies it for n frames; a stream of five-digit values runs at
// one request per five frames. Digit extraction takes four pipeline stages, one place
// value per stage; the digits then pass the queue and the output register.
// Reset clears the pipeline valid bits, the queue pointers and the output valid bit.
// A stall on m_axis fills the output register, then the queue, then the front pipeline;
// only then does s_axis_tready drop.
module decimal_seven_segment_display_frames_core import dssd_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] segments, [15:8] digit_select
  output logic        m_axis_tlast
);

  logic            fq_valid, fq_ready;
  dssd_entry_t     fq_entry;
  logic            qb_valid, qb_pop;
  dssd_entry_t     qb_entry;
  logic [SegW-1:0] segments, digit_select;

  // Front end: value in, five decimal digits plus the index of the first shown digit out.
  dssd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_entry_o  (fq_entry)
  );

  // The queue lets digit extraction run ahead while frames are still going out.
  dssd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_entry_i (fq_entry),
    .rd_valid_o (qb_valid),
    .rd_pop_i   (qb_pop),
    .rd_entry_o (qb_entry)
  );

  // Back end: one registered frame per cycle unless m_axis stalls, the queue entry is released on the units frame.
  dssd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (qb_valid),
    .q_pop_o        (qb_pop),
    .q_entry_i      (qb_entry),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_segments_o (segments),
    .out_select_o   (digit_select),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {digit_select, segments};

endmodule

// ===== hdl/dssd_checker.sv =====
// Port-level checker for the seven-segment frame generator, bound to the top level.
module dssd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled frame holds its content.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("frame changed while stalled");

  // Exactly one position is selected, by a low bit in one of select bits 3 to 7.
  a_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(~m_axis_tdata[15:8]) && m_axis_tdata[10:8] == 3'b111)
    else $error("bad digit select");

  // The units position carries the end of run and nothing else does.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tlast == (m_axis_tdata[15:8] == 8'h7f))
    else $error("end of run on wrong position");

  // Every frame lights some segment and never the decimal point.
  a_segs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[7] && m_axis_tdata[6:0] != 7'd0)
    else $error("bad segment pattern");

endmodule

bind decimal_seven_segment_display_frames_core dssd_checker u_dssd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/decimal_seven_segment_display_frames_core_test.sv =====
// Self-checking testbench for the decimal seven-segment frame generator.
module decimal_seven_segment_display_frames_core_test import dssd_pkg::*;;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned MaxReports = 10;

  // Digit patterns for a common-cathode display, segment a in bit 0.
  localparam logic [SegW-1:0] DIGIT_SEGMENTS [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };
  // Select byte of the ten-thousands position; each lower digit moves the low bit up one.
  localparam logic [SegW-1:0] TOP_POSITION_BIT = 8'h08;

  typedef struct packed {
    logic [SegW-1:0] segments;
    logic [SegW-1:0] digit_select;
    logic            last;
  } frame_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ValueW-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tlast;

  frame_t      pending_frames[$];
  int unsigned values_sent;
  int unsigned frames_checked;
  int unsigned frame_errors;
  int unsigned cycle_count;
  bit          source_gaps;
  bit          sink_gaps;
  bit          long_hold_req;

  decimal_seven_segment_display_frames_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("decimal_seven_segment_display_frames_core verification failed");
    $finish;
  end

  // Queues the frames of one value: leading zeros blanked, the units digit always shown.
  function automatic void predict_frames(input logic [ValueW-1:0] value);
    int unsigned rest;
    int unsigned place;
    int unsigned digit;
    bit          shown;
    frame_t      frame;
    rest  = value;
    place = 10000;
    shown = 1'b0;
    for (int pos = 0; pos < NumDigits; pos++) begin
      digit = rest / place;
      rest  = rest % place;
      if (digit != 0 || pos == NumDigits - 1) begin
        shown = 1'b1;
      end
      if (shown) begin
        frame.segments     = DIGIT_SEGMENTS[digit];
        frame.digit_select = ~(TOP_POSITION_BIT << pos);
        frame.last         = (pos == NumDigits - 1);
        pending_frames.push_back(frame);
      end
      place = place / 10;
    end
  endfunction

  // Values spread over every digit count, plus some built to carry interior zeros.
  function automatic logic [ValueW-1:0] random_value();
    int unsigned shape;
    int unsigned v;
    shape = $urandom_range(0, 6);
    case (shape)
      0:       v = $urandom_range(0, 9);
      1:       v = $urandom_range(10, 99);
      2:       v = $urandom_range(100, 999);
      3:       v = $urandom_range(1000, 9999);
      4:       v = $urandom_range(10000, 65535);
      5: begin
        v = $urandom_range(1, 6) * 10000;
        for (int p = 1000; p >= 1; p = p / 10) begin
          if ($urandom_range(0, 1) != 0) begin
            v = v + $urandom_range(1, 9) * p;
          end
        end
        if (v > 65535) begin
          v = v - 10000;
        end
      end
      default: v = $urandom;
    endcase
    return ValueW'(v);
  endfunction

  function automatic int unsigned idle_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Offers one value and holds it until the block takes the request.
  task automatic send_value(input logic [ValueW-1:0] value);
    int unsigned gap;
    s_axis_tdata  <= value;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frames(value);
    values_sent++;
    gap = (source_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drops valid and waits on the clock, so the next burst can raise it again cleanly.
  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  // Frame sink: random stalls when enabled, or one long hold-off on request.
  initial begin : frame_sink
    int unsigned gap;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        gap = idle_length();
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Each accepted frame is compared against the oldest predicted one.
  always @(posedge clk_i) begin
    frame_t want;
    frame_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.segments     = m_axis_tdata[7:0];
      got.digit_select = m_axis_tdata[15:8];
      got.last         = m_axis_tlast;
      if (pending_frames.size() == 0) begin
        frame_errors++;
        if (frame_errors <= MaxReports) begin
          $display("ERROR: unexpected frame seg=%h sel=%h last=%b",
                   got.segments, got.digit_select, got.last);
        end
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (got != want) begin
          frame_errors++;
          if (frame_errors <= MaxReports) begin
            $display("ERROR: frame %0d expected seg=%h sel=%h last=%b, got seg=%h sel=%h last=%b",
                     frames_checked, want.segments, want.digit_select, want.last,
                     got.segments, got.digit_select, got.last);
          end
        end
      end
    end
  end

  // Extremes, each digit count, every digit glyph, interior zeros and alternating bits.
  task automatic test_directed();
    logic [ValueW-1:0] values [20] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999,
      16'd10000, 16'd10001, 16'd10203, 16'd40509, 16'd12345, 16'd6789, 16'd65535,
      16'h8000, 16'h5555, 16'haaaa, 16'd50000
    };
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    foreach (values[i]) begin
      send_value(values[i]);
    end
    end_burst();
  endtask

  task automatic test_full_rate();
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    repeat (40) send_value(random_value());
    end_burst();
  endtask

  task automatic test_random_idling();
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
    repeat (70) send_value(random_value());
    end_burst();
  endtask

  // The sink holds off long enough that the block fills and drops s_axis_tready.
  task automatic test_output_stall();
    source_gaps   = 1'b0;
    sink_gaps     = 1'b0;
    long_hold_req = 1'b1;
    repeat (20) send_value(random_value());
    end_burst();
  endtask

  // The source waits for every frame before resuming, so the block restarts from empty.
  task automatic test_drain_pause();
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
    repeat (10) send_value(random_value());
    end_burst();
    wait_for_drain();
    repeat (10) send_value(random_value());
    end_burst();
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_rate();
    test_random_idling();
    test_output_stall();
    test_drain_pause();

    wait_for_drain();
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d values (extremes, every digit count, interior zeros, random widths)",
             values_sent);
    $display("and checked %0d frames under source gaps, sink stalls and a long output stall.",
             frames_checked);
    if (frame_errors == 0 && pending_frames.size() == 0) begin
      $display("decimal_seven_segment_display_frames_core verification clean");
    end else begin
      $display("decimal_seven_segment_display_frames_core verification failed");
    end
    $finish;
  end

endmodule
